// ===== rtl/core/keyed_expiring_fact_table_assert.svh =====
// Assertion macros for the keyed expiring fact table.
// Expects signals named clock and reset in the including scope.
`ifndef KEYED_EXPIRING_FACT_TABLE_ASSERT_SVH
`define KEYED_EXPIRING_FACT_TABLE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define KEF_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define KEF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/kef_pkg.sv =====
// Shared types and constants for the keyed expiring fact table.
// No dependencies; used by the interfaces and all core modules.
`default_nettype none

package kef_pkg;

   localparam int unsigned TABLE_DEPTH_DEFAULT = 64;
   localparam int unsigned CSR_INDEX_WIDTH     = 1;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNKNOWN_STATE = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NEVER_EXPIRES = 1'd1;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3   // ignored, answers all zero
   } kef_op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_CAP = 2'd1,
      ST_FULL     = 2'd2
   } kef_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_EVAL,
      S_OUT
   } kef_state_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [31:0]        capability_key;
      logic [31:0]        subject_class_key;
      logic [63:0]        subject_key;
      logic [7:0]         entry_state;
      logic [31:0]        entry_uncertainty;
      logic signed [63:0] entry_observed;
      logic signed [63:0] entry_expiry;
      logic [31:0]        entry_latency;
      logic signed [63:0] query_now;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               found_valid;
      logic [7:0]         view_state;
      logic [31:0]        view_uncertainty;
      logic signed [63:0] view_observed;
      logic [31:0]        view_latency;
      logic               stale_flag;
      logic               uncertain_flag;
   } rsp_item_type;

   typedef struct packed {
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [63:0]                data;
   } csr_item_type;

   typedef struct packed {
      logic [31:0]        capability;
      logic [31:0]        subject_class;
      logic [63:0]        subject;
      logic [7:0]         state;
      logic [31:0]        uncertainty;
      logic signed [63:0] observed;
      logic signed [63:0] expiry;
      logic [31:0]        latency;
   } rec_type;

   // controller -> datapath
   typedef struct packed {
      logic           take;
      logic           set_status;
      kef_status_type status;
      logic           append;
      logic           wipe;
      logic           scan_start;
      logic           issue;
      logic           hit;
      logic           eval;
      logic           load_out;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      kef_op_type kind;
      logic       cap_zero;
      logic       full;
      logic       match;
      logic       scan_done;
      logic       out_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/core/kef_req_if.sv =====
// Request channel interface: valid/ready plus one input item.
// Depends on kef_pkg.
`default_nettype none

interface kef_req_if;
   import kef_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/kef_rsp_if.sv =====
// Response channel interface: valid/ready plus one result item.
// Depends on kef_pkg.
`default_nettype none

interface kef_rsp_if;
   import kef_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/kef_csr_if.sv =====
// Register write channel interface: valid/ready, register index and data.
// Depends on kef_pkg.
`default_nettype none

interface kef_csr_if;
   import kef_pkg::*;
   logic         valid;
   logic         ready;
   csr_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/kef_datapath.sv =====
// Datapath: record memory, record count, scan index, expiry/stale math,
// register file and response register. Depends on kef_pkg.
`default_nettype none

module kef_datapath #(
   parameter int unsigned TABLE_DEPTH = kef_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  kef_pkg::req_item_type req_item,
   input  logic                  csr_write,
   input  kef_pkg::csr_item_type csr_item,
   input  kef_pkg::cmd_type      cmd,
   output kef_pkg::sts_type      sts,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output kef_pkg::rsp_item_type rsp_item
);
   import kef_pkg::*;

   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   rec_type            mem [TABLE_DEPTH];
   rec_type            rdata_ff;
   rec_type            rec_new;
   req_item_type       item_ff;
   logic [7:0]         unknown_ff;
   logic [63:0]        never_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      idx_ff;
   logic               rd_valid_ff;
   logic               found_ff;
   logic               expired_ff;
   logic signed [63:0] age_ff;
   kef_status_type     status_ff;
   logic               rsp_valid_ff;
   rsp_item_type       rsp_ff;
   rsp_item_type       rsp_in;

   always_comb begin
      rec_new.capability    = item_ff.capability_key;
      rec_new.subject_class = item_ff.subject_class_key;
      rec_new.subject       = item_ff.subject_key;
      rec_new.state         = item_ff.entry_state;
      rec_new.uncertainty   = item_ff.entry_uncertainty;
      rec_new.observed      = item_ff.entry_observed;
      rec_new.expiry        = item_ff.entry_expiry;
      rec_new.latency       = item_ff.entry_latency;
   end

   // record memory: one write port at the fill position, one registered read
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         mem[count_ff[AW-1:0]] <= rec_new;
      end
      if (cmd.issue) begin
         rdata_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         item_ff <= req_item;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.eval) begin
         expired_ff <= (rdata_ff.expiry != never_ff) &&
                       (rdata_ff.expiry <= item_ff.query_now);
         age_ff     <= item_ff.query_now - rdata_ff.observed;
      end
      if (cmd.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unknown_ff   <= '0;
         never_ff     <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_item.index)
               CSR_UNKNOWN_STATE: unknown_ff <= csr_item.data[7:0];
               CSR_NEVER_EXPIRES: never_ff   <= csr_item.data;
            endcase
         end
         if (cmd.wipe) begin
            count_ff <= '0;
         end else if (cmd.append) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.scan_start) begin
            idx_ff      <= '0;
            rd_valid_ff <= 1'b0;
            found_ff    <= 1'b0;
         end else begin
            rd_valid_ff <= cmd.issue;
            if (cmd.issue) begin
               idx_ff <= idx_ff + CW'(1);
            end
            if (cmd.hit) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      rsp_in        = '0;
      rsp_in.status = status_ff;
      if (kef_op_type'(item_ff.kind) == OP_QUERY) begin
         rsp_in.view_state = unknown_ff;
         if (found_ff && !expired_ff) begin
            rsp_in.found_valid      = 1'b1;
            rsp_in.view_state       = rdata_ff.state;
            rsp_in.view_uncertainty = rdata_ff.uncertainty;
            rsp_in.view_observed    = rdata_ff.observed;
            rsp_in.view_latency     = rdata_ff.latency;
            // age is signed; a negative age is never stale
            rsp_in.stale_flag       = (rdata_ff.latency != '0) &&
                                      (age_ff > $signed({32'b0, rdata_ff.latency}));
            rsp_in.uncertain_flag   = (rdata_ff.uncertainty != '0);
         end
      end
   end

   always_comb begin
      sts.kind      = kef_op_type'(item_ff.kind);
      sts.cap_zero  = (item_ff.capability_key == '0);
      sts.full      = (count_ff == CW'(TABLE_DEPTH));
      sts.match     = rd_valid_ff &&
                      (rdata_ff.capability == item_ff.capability_key) &&
                      (rdata_ff.subject_class == item_ff.subject_class_key) &&
                      (rdata_ff.subject == item_ff.subject_key);
      sts.scan_done = (idx_ff == count_ff);
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/kef_ctrl.sv =====
// Controller: sequences add, clear and query scan over the datapath.
// Depends on kef_pkg.
`default_nettype none

module kef_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  kef_pkg::sts_type sts,
   output kef_pkg::cmd_type cmd
);
   import kef_pkg::*;

   kef_state_type state_ff;
   kef_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.status = ST_OK;
      req_ready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.set_status = 1'b1;
            state_in       = S_OUT;
            unique case (sts.kind)
               OP_ADD: begin
                  // zero capability is checked before fullness
                  priority if (sts.cap_zero) begin
                     cmd.status = ST_ZERO_CAP;
                  end else if (sts.full) begin
                     cmd.status = ST_FULL;
                  end else begin
                     cmd.append = 1'b1;
                  end
               end
               OP_CLEAR: begin
                  cmd.wipe = 1'b1;
               end
               OP_QUERY: begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
               OP_NONE: begin
               end
            endcase
         end
         S_SCAN: begin
            // compare last read while issuing the next; stop on first hit
            priority if (sts.match) begin
               cmd.hit  = 1'b1;
               state_in = S_EVAL;
            end else if (sts.scan_done) begin
               state_in = S_OUT;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/keyed_expiring_fact_table.sv =====
// Top level of the keyed expiring fact table: controller plus datapath.
// Depends on kef_pkg, the channel interfaces and the assertion macros.
//
//   channel  direction  carries
//   req_if   in         one operation: add, clear or query, with key and record
//   rsp_if   out        one result per operation
//   csr_if   in         register index and 64-bit write data
//
// Add, clear and the ignored code go from the execute to the output state.
// A query reads one record per cycle from the memory read port and stops at
// the first hit; a hit passes the evaluate state before the output state.
// Reset empties the table at once; stored records are not cleared.
// One item at a time; a finished result waits in the output register and the
// next item is taken as soon as the previous result has been placed there.
`default_nettype none

`include "keyed_expiring_fact_table_assert.svh"

module keyed_expiring_fact_table #(
   parameter int unsigned TABLE_DEPTH = kef_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   kef_req_if.sink   req_if,
   kef_rsp_if.source rsp_if,
   kef_csr_if.sink   csr_if
);
   import kef_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    req_transfer;

   assign csr_if.ready = 1'b1;
   assign req_transfer = req_if.valid && req_if.ready;

   kef_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   kef_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_if.payload),
      .csr_write (csr_if.valid),
      .csr_item  (csr_if.payload),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_item  (rsp_if.payload)
   );

   `KEF_ASSERT_NEXT(a_one_at_a_time, req_transfer, !req_if.ready, "request taken while busy")
   `KEF_ASSERT_SAME(a_append_legal, cmd.append, !sts.full && !sts.cap_zero, "bad append")
   `KEF_ASSERT_SAME(a_no_overwrite, cmd.load_out, !rsp_if.valid || rsp_if.ready, "result lost")
   `KEF_ASSERT_NEXT(a_result_shown, cmd.load_out, rsp_if.valid, "result not presented")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench for keyed_expiring_fact_table: directed then random add, clear and query traffic,
// scored against an in-bench model of the table. Needs kef_pkg, the three channel
// interfaces and the RTL top level; reads no files.

module tb;
   import kef_pkg::*;

   localparam int unsigned DEPTH         = 64;
   localparam int unsigned IDLE_LIMIT    = 3000;
   localparam int unsigned SETTLE_CYCLES = 100;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned HOLD_AT       = 300;
   localparam int unsigned MAX_REPORTS   = 40;

   localparam logic signed [63:0] MAX_TICK = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] MIN_TICK = {1'b1, 63'd0};

   typedef struct packed {
      logic [31:0] cap;
      logic [31:0] skind;
      logic [63:0] subj;
   } fact_key_type;

   logic clock;
   logic reset;

   kef_req_if req_if ();
   kef_rsp_if rsp_if ();
   kef_csr_if csr_if ();

   keyed_expiring_fact_table #(.TABLE_DEPTH(DEPTH)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // model of the table and its registers
   rec_type            fact_mem [DEPTH];
   int unsigned        fact_count;
   logic [7:0]         unknown_code;
   logic signed [63:0] never_tick;

   req_item_type       pending_ops [$];
   rsp_item_type       expected_views [$];
   int unsigned        mismatches;

   fact_key_type       key_pool [6];
   logic signed [63:0] tick_base;

   always #5 clock = ~clock;

   function automatic rsp_item_type apply_op(req_item_type op);
      rsp_item_type       res;
      rec_type            rec;
      logic signed [63:0] age;
      int                 hit_at;
      int                 i;
      res = '0;
      hit_at = -1;
      case (kef_op_type'(op.kind))
         OP_ADD: begin
            if (op.capability_key == 32'd0) begin
               res.status = ST_ZERO_CAP;
            end else if (fact_count >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               fact_mem[fact_count] = {op.capability_key, op.subject_class_key, op.subject_key,
                                       op.entry_state, op.entry_uncertainty, op.entry_observed,
                                       op.entry_expiry, op.entry_latency};
               fact_count++;
            end
         end
         OP_CLEAR: begin
            fact_count = 0;
         end
         OP_QUERY: begin
            for (i = 0; i < fact_count; i++) begin
               if (hit_at < 0 && fact_mem[i].capability == op.capability_key &&
                   fact_mem[i].subject_class == op.subject_class_key &&
                   fact_mem[i].subject == op.subject_key) begin
                  hit_at = i;
               end
            end
            res.view_state = unknown_code;
            if (hit_at >= 0) begin
               rec = fact_mem[hit_at];
               if (!(rec.expiry != never_tick && $signed(rec.expiry) <= $signed(op.query_now))) begin
                  res.found_valid      = 1'b1;
                  res.view_state       = rec.state;
                  res.view_uncertainty = rec.uncertainty;
                  res.view_observed    = rec.observed;
                  res.view_latency     = rec.latency;
                  // age wraps at 64 bits and compares signed
                  age = op.query_now - rec.observed;
                  res.stale_flag = (rec.latency != 32'd0) &&
                                   ($signed(age) > $signed({32'd0, rec.latency}));
                  res.uncertain_flag = (rec.uncertainty != 32'd0);
               end
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string what);
      if (mismatches < MAX_REPORTS) $display("%0t mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_view(rsp_item_type got);
      rsp_item_type want;
      if (expected_views.size() == 0) begin
         report_mismatch($sformatf("unexpected result %h", got));
         return;
      end
      want = expected_views.pop_front();
      if (got.status !== want.status)
         report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.found_valid !== want.found_valid)
         report_mismatch($sformatf("found_valid %b, want %b", got.found_valid, want.found_valid));
      if (got.view_state !== want.view_state)
         report_mismatch($sformatf("view_state %h, want %h", got.view_state, want.view_state));
      if (got.view_uncertainty !== want.view_uncertainty)
         report_mismatch($sformatf("view_uncertainty %h, want %h",
                                   got.view_uncertainty, want.view_uncertainty));
      if (got.view_observed !== want.view_observed)
         report_mismatch($sformatf("view_observed %h, want %h",
                                   got.view_observed, want.view_observed));
      if (got.view_latency !== want.view_latency)
         report_mismatch($sformatf("view_latency %h, want %h",
                                   got.view_latency, want.view_latency));
      if (got.stale_flag !== want.stale_flag)
         report_mismatch($sformatf("stale_flag %b, want %b", got.stale_flag, want.stale_flag));
      if (got.uncertain_flag !== want.uncertain_flag)
         report_mismatch($sformatf("uncertain_flag %b, want %b",
                                   got.uncertain_flag, want.uncertain_flag));
   endtask

   // sender: bursts of transfers separated by random gaps
   int unsigned burst_left;
   int unsigned gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left = 1;
         gap_left   = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_views.push_back(apply_op(req_if.payload));
            void'(pending_ops.pop_front());
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               req_if.valid   <= 1'b1;
               req_if.payload <= pending_ops[0];
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern steps through four modes on a phase counter, plus one long hold-off
   int unsigned stall_phase;
   int unsigned hold_left;
   int unsigned views_seen;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_phase = 0;
         hold_left   = 0;
         views_seen  = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            check_view(rsp_if.payload);
            views_seen++;
            if (views_seen == HOLD_AT) hold_left = HOLD_CYCLES;
         end
         stall_phase++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case ((stall_phase / 256) % 4)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= 1'($urandom_range(0, 1));
               2: rsp_if.ready <= (stall_phase % 7) < 2;
               default: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   int unsigned quiet_cycles;

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] index, logic [63:0] data);
      @(posedge clock);
      csr_if.valid   <= 1'b1;
      csr_if.payload <= {index, data};
      do @(posedge clock); while (!csr_if.ready);
      if (index == CSR_UNKNOWN_STATE) begin
         unknown_code = data[7:0];
      end else begin
         never_tick = data;
      end
      csr_if.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_ops.size() != 0 || expected_views.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic logic signed [63:0] near_tick(int lo, int hi);
      int off;
      off = lo + int'($urandom_range(0, hi - lo));
      return tick_base + off;
   endfunction

   // keys that differ from key 0 in one part only, plus the field extremes
   function automatic void setup_phase();
      key_pool[0] = {32'($urandom_range(1, 32'hFFFF_FFFE)), 32'($urandom), {$urandom, $urandom}};
      key_pool[1] = key_pool[0];
      key_pool[1].cap = key_pool[0].cap + 32'd1;
      key_pool[2] = key_pool[0];
      key_pool[2].skind = key_pool[0].skind ^ (32'd1 << $urandom_range(0, 31));
      key_pool[3] = key_pool[0];
      key_pool[3].subj = key_pool[0].subj ^ (64'd1 << $urandom_range(0, 63));
      key_pool[4] = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
      key_pool[5] = {32'd1, 32'd0, 64'd0};
      case ($urandom_range(0, 2))
         0: tick_base = MAX_TICK - 30;
         1: tick_base = MIN_TICK + 30;
         default: tick_base = {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_item_type random_op(int unsigned clear_pct);
      req_item_type op;
      fact_key_type key;
      int unsigned  pick;
      pick = $urandom_range(0, 99);
      if (pick < clear_pct) op.kind = OP_CLEAR;
      else if (pick < clear_pct + 2) op.kind = OP_NONE;
      else if (pick < clear_pct + 50) op.kind = OP_ADD;
      else op.kind = OP_QUERY;
      if ($urandom_range(0, 9) < 8) key = key_pool[$urandom_range(0, 5)];
      else key = {32'($urandom), 32'($urandom), {$urandom, $urandom}};
      if (op.kind == OP_ADD && $urandom_range(0, 29) == 0) key.cap = 32'd0;
      op.capability_key    = key.cap;
      op.subject_class_key = key.skind;
      op.subject_key       = key.subj;
      op.entry_state       = 8'($urandom);
      op.entry_uncertainty = ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom);
      op.entry_observed    = near_tick(-40, 40);
      case ($urandom_range(0, 9))
         0, 1: op.entry_expiry = never_tick;
         2: op.entry_expiry = {$urandom, $urandom};
         default: op.entry_expiry = near_tick(-20, 60);
      endcase
      case ($urandom_range(0, 4))
         0: op.entry_latency = 32'd0;
         1: op.entry_latency = 32'($urandom);
         default: op.entry_latency = 32'($urandom_range(1, 50));
      endcase
      op.query_now = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : near_tick(-20, 80);
      return op;
   endfunction

   task automatic queue_random(int unsigned count, int unsigned clear_pct);
      int unsigned n;
      for (n = 0; n < count; n++) pending_ops.push_back(random_op(clear_pct));
   endtask

   function automatic req_item_type mk_op(kef_op_type kind, fact_key_type key, logic [7:0] state,
                                          logic [31:0] unc, logic signed [63:0] observed,
                                          logic signed [63:0] expiry, logic [31:0] lat,
                                          logic signed [63:0] now);
      req_item_type op;
      op.kind              = kind;
      op.capability_key    = key.cap;
      op.subject_class_key = key.skind;
      op.subject_key       = key.subj;
      op.entry_state       = state;
      op.entry_uncertainty = unc;
      op.entry_observed    = observed;
      op.entry_expiry      = expiry;
      op.entry_latency     = lat;
      op.query_now         = now;
      return op;
   endfunction

   initial begin
      fact_key_type k_ones, k_low, k_mid, k_mid_kind, k_top, k_top_next;
      req_item_type op;
      clock          = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.payload = '0;
      unknown_code   = 8'd0;
      never_tick     = '0;
      fact_count     = 0;
      mismatches     = 0;
      quiet_cycles   = 0;
      tick_base      = '0;

      k_ones     = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
      k_low      = {32'd1, 32'd0, 64'd0};
      k_mid      = {32'h1234_5678, 32'd7, 64'h0123_4567_89AB_CDEF};
      k_mid_kind = {32'h1234_5678, 32'd6, 64'h0123_4567_89AB_CDEF};
      k_top      = {32'h8000_0000, 32'h8000_0000, 64'h8000_0000_0000_0000};
      k_top_next = {32'h8000_0000, 32'h8000_0000, 64'h8000_0000_0000_0001};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, registers at reset values (zero expiry never expires)
      pending_ops.push_back(mk_op(OP_QUERY, k_ones, 8'h00, 32'd0, 0, 0, 32'd0, 0));
      pending_ops.push_back(mk_op(OP_ADD, {32'd0, 32'd5, 64'd9}, 8'h11, 32'd1, 1, 2, 32'd3, 0));
      pending_ops.push_back(mk_op(OP_ADD, k_ones, 8'hFF, 32'd0, 100, 0, 32'd0, 0));
      pending_ops.push_back(mk_op(OP_QUERY, k_ones, 8'h00, 32'd0, 0, 0, 32'd0, MAX_TICK));
      pending_ops.push_back(mk_op(OP_ADD, k_low, 8'h00, 32'hFFFF_FFFF, MAX_TICK, MAX_TICK,
                                  32'd5, 0));
      // age wraps from max to min and comes out as one
      pending_ops.push_back(mk_op(OP_QUERY, k_low, 8'h00, 32'd0, 0, 0, 32'd0, MIN_TICK));
      pending_ops.push_back(mk_op(OP_QUERY, k_low, 8'h00, 32'd0, 0, 0, 32'd0, MAX_TICK));
      pending_ops.push_back(mk_op(OP_ADD, k_mid, 8'hA5, 32'h0001_0000, -10, 1000, 32'd3, 0));
      pending_ops.push_back(mk_op(OP_QUERY, k_mid, 8'h00, 32'd0, 0, 0, 32'd0, -7));
      pending_ops.push_back(mk_op(OP_QUERY, k_mid, 8'h00, 32'd0, 0, 0, 32'd0, -6));
      pending_ops.push_back(mk_op(OP_QUERY, k_mid, 8'h00, 32'd0, 0, 0, 32'd0, 999));
      pending_ops.push_back(mk_op(OP_QUERY, k_mid, 8'h00, 32'd0, 0, 0, 32'd0, 1000));
      // same key again: queries must still find the older record
      pending_ops.push_back(mk_op(OP_ADD, k_mid, 8'h5A, 32'd0, 0, 0, 32'd0, 0));
      pending_ops.push_back(mk_op(OP_QUERY, k_mid, 8'h00, 32'd0, 0, 0, 32'd0, 500));
      pending_ops.push_back(mk_op(OP_QUERY, k_mid_kind, 8'h00, 32'd0, 0, 0, 32'd0, 500));
      pending_ops.push_back(mk_op(OP_ADD, k_top, 8'h80, 32'd1, MIN_TICK, 0, 32'hFFFF_FFFF, 0));
      pending_ops.push_back(mk_op(OP_QUERY, k_top, 8'h00, 32'd0, 0, 0, 32'd0, MAX_TICK));
      pending_ops.push_back(mk_op(OP_ADD, k_top_next, 8'h01, 32'd0, 0, 0, 32'hFFFF_FFFF, 0));
      pending_ops.push_back(mk_op(OP_QUERY, k_top_next, 8'h00, 32'd0, 0, 0, 32'd0,
                                  64'sh1_0000_0000));
      op = '1;
      op.kind = OP_NONE;
      pending_ops.push_back(op);
      pending_ops.push_back(mk_op(OP_CLEAR, k_ones, 8'h00, 32'd0, 0, 0, 32'd0, 0));
      pending_ops.push_back(mk_op(OP_QUERY, k_ones, 8'h00, 32'd0, 0, 0, 32'd0, 0));
      pending_ops.push_back(mk_op(OP_ADD, {32'd0, 32'd0, 64'd0}, 8'h00, 32'd0, 0, 0, 32'd0, 0));
      wait_drained();

      write_reg(CSR_UNKNOWN_STATE, 64'hFF);
      write_reg(CSR_NEVER_EXPIRES, MAX_TICK);
      setup_phase();
      @(negedge clock);
      queue_random(340, 4);
      wait_drained();

      // no clears here, so the table fills and adds are refused
      write_reg(CSR_UNKNOWN_STATE, 64'h00);
      write_reg(CSR_NEVER_EXPIRES, MIN_TICK);
      setup_phase();
      @(negedge clock);
      queue_random(340, 0);
      wait_drained();

      setup_phase();
      write_reg(CSR_UNKNOWN_STATE, 64'($urandom_range(1, 254)));
      write_reg(CSR_NEVER_EXPIRES, tick_base + 5);
      @(negedge clock);
      queue_random(320, 1);
      wait_drained();

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
